// ===== hdl/dq_pkg.sv =====
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Row-wide controls, already qualified by the full and empty checks.
    typedef struct packed {
        logic shift_back;   // push at the front: every word moves one cell back
        logic shift_front;  // pop from the front: every word moves one cell forward
        logic push_back;    // the first free cell takes the new word
        logic pop_back;     // the last occupied cell empties
    } t_cell_ctrl;

endpackage

// ===== hdl/dq_cell.sv =====
module dq_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dq_pkg::t_cell_ctrl               i_ctrl,
    input  logic [dq_pkg::DATA_WIDTH-1:0]    i_word,
    input  logic [dq_pkg::DATA_WIDTH-1:0]    i_left_data,
    input  logic                             i_left_occ,
    input  logic [dq_pkg::DATA_WIDTH-1:0]    i_right_data,
    input  logic                             i_right_occ,
    output logic [dq_pkg::DATA_WIDTH-1:0]    o_data,
    output logic                             o_occ,
    output logic [dq_pkg::DATA_WIDTH-1:0]    o_tail_data
);

    logic [dq_pkg::DATA_WIDTH-1:0] r_data;
    logic [dq_pkg::DATA_WIDTH-1:0] n_data;
    logic                          r_occ;
    logic                          n_occ;
    logic                          w_tail;
    logic                          w_first_free;

    // The tail is the last occupied cell; the first free cell sits right behind it.
    assign w_tail       = r_occ & ~i_right_occ;
    assign w_first_free = ~r_occ & i_left_occ;

    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        priority if (i_ctrl.shift_back) begin
            n_data = i_left_data;
            n_occ  = i_left_occ;
        end else if (i_ctrl.shift_front) begin
            n_data = i_right_data;
            n_occ  = i_right_occ;
        end else if (i_ctrl.push_back && w_first_free) begin
            n_data = i_word;
            n_occ  = 1'b1;
        end else if (i_ctrl.pop_back && w_tail) begin
            n_occ  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_data      = r_data;
    assign o_occ       = r_occ;
    assign o_tail_data = w_tail ? r_data : '0;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue of dq_pkg::DEPTH words held in a row of cells, the
// front word always in the first cell. A transaction is taken whenever start is
// high and busy is low; busy is high during reset and until the release of reset
// is registered; from then on one operation is accepted every clock cycle. Each operation
// gives exactly one result, registered and shown on the o_ ports with o_valid high
// for a single cycle; the receiver cannot stall, so results must be
// captured then. o_is_empty and o_is_full describe the deque after the operation.
// A push on a full deque is dropped with status overflow; a pop or peek on an
// empty deque returns zero with status underflow.
module double_ended_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_kind,
    input  logic [dq_pkg::DATA_WIDTH-1:0]    i_push_value,
    output logic                             o_valid,
    output logic [dq_pkg::DATA_WIDTH-1:0]    o_out_value,
    output logic [1:0]                       o_status,
    output logic                             o_is_empty,
    output logic                             o_is_full
);

    logic [dq_pkg::DATA_WIDTH-1:0] w_data      [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_WIDTH-1:0] w_tail_data [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_WIDTH-1:0] w_left_data [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_WIDTH-1:0] w_right_data[dq_pkg::DEPTH];
    logic [dq_pkg::DEPTH-1:0]      w_occ;
    logic [dq_pkg::DEPTH-1:0]      w_left_occ;
    logic [dq_pkg::DEPTH-1:0]      w_right_occ;
    logic [dq_pkg::DATA_WIDTH-1:0] w_back_value;

    logic                          r_alive;
    logic                          r_valid;
    logic [dq_pkg::DATA_WIDTH-1:0] r_value;
    logic [dq_pkg::DATA_WIDTH-1:0] n_value;
    dq_pkg::t_status               r_status;
    dq_pkg::t_status               n_status;
    dq_pkg::t_cell_ctrl            w_ctrl;
    dq_pkg::t_kind                 w_kind;
    logic                          w_accept;
    logic                          w_empty;
    logic                          w_full;

    assign busy     = ~r_alive;
    assign w_accept = start & ~busy;
    assign w_kind   = dq_pkg::t_kind'(i_kind);
    assign w_empty  = ~w_occ[0];
    assign w_full   = w_occ[dq_pkg::DEPTH-1];

    // Neighbour wiring: the first cell sees the incoming word as an occupied
    // left neighbour, the last cell sees an empty right neighbour.
    always_comb begin
        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
            if (i == 0) begin
                w_left_data[i] = i_push_value;
                w_left_occ[i]  = 1'b1;
            end else begin
                w_left_data[i] = w_data[i-1];
                w_left_occ[i]  = w_occ[i-1];
            end
            if (i == dq_pkg::DEPTH - 1) begin
                w_right_data[i] = '0;
                w_right_occ[i]  = 1'b0;
            end else begin
                w_right_data[i] = w_data[i+1];
                w_right_occ[i]  = w_occ[i+1];
            end
        end
    end

    // Only the tail cell drives its word, so an OR across the row picks it out.
    always_comb begin
        w_back_value = '0;
        for (int i = 0; i < dq_pkg::DEPTH; i++) begin
            w_back_value = w_back_value | w_tail_data[i];
        end
    end

    // Cell controls for this transaction.
    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            unique case (w_kind)
                dq_pkg::KIND_PUSH_FRONT: w_ctrl.shift_back  = ~w_full;
                dq_pkg::KIND_PUSH_BACK:  w_ctrl.push_back   = ~w_full;
                dq_pkg::KIND_POP_FRONT:  w_ctrl.shift_front = ~w_empty;
                dq_pkg::KIND_POP_BACK:   w_ctrl.pop_back    = ~w_empty;
                default:                 w_ctrl = '0;
            endcase
        end
    end

    // Result value and status for this transaction.
    always_comb begin
        n_value  = '0;
        n_status = dq_pkg::ST_OK;
        unique case (w_kind)
            dq_pkg::KIND_PUSH_FRONT,
            dq_pkg::KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_status = dq_pkg::ST_OVERFLOW;
                end
            end
            dq_pkg::KIND_POP_FRONT,
            dq_pkg::KIND_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_value = w_data[0];
                end
            end
            dq_pkg::KIND_POP_BACK: begin
                if (w_empty) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_value = w_back_value;
                end
            end
            default: begin
                n_value  = '0;
                n_status = dq_pkg::ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
        dq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_word       (i_push_value),
            .i_left_data  (w_left_data[g]),
            .i_left_occ   (w_left_occ[g]),
            .i_right_data (w_right_data[g]),
            .i_right_occ  (w_right_occ[g]),
            .o_data       (w_data[g]),
            .o_occ        (w_occ[g]),
            .o_tail_data  (w_tail_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
        if (!i_rst_n) begin
            r_alive <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_alive <= 1'b1;
            r_valid <= w_accept;
        end
    end

    // The cells have already taken the operation when the result is shown, so
    // the flags come straight from the first and last cells.
    assign o_valid     = r_valid;
    assign o_out_value = r_value;
    assign o_status    = r_status;
    assign o_is_empty  = w_empty;
    assign o_is_full   = w_full;

`ifndef SYNTHESIS
    // Occupied cells always form an unbroken run from the front.
    a_occ_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ & ~{w_occ[dq_pkg::DEPTH-2:0], 1'b1}) == '0)
        else $error("occupied cells are not contiguous from the front");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted transaction gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result strobe without a transaction");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dq_pkg::ST_OVERFLOW) |-> o_is_full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dq_pkg::ST_UNDERFLOW) |-> (o_is_empty && o_out_value == '0))
        else $error("underflow reported while not empty or with data");
`endif

endmodule
